FILE: rtl/core/mpq_pkg.sv
`timescale 1ns / 1ps

package mpq_pkg;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic load;
        logic push;
        logic flag_full;
        logic flag_empty;
        logic scan_start;
        logic scan_step;
        logic shift_start;
        logic shift_step;
        logic finish_remove;
        logic out_load;
    } mpq_cmd_t;

    typedef struct packed {
        logic op_remove;
        logic is_full;
        logic is_empty;
        logic scan_last;
        logic shift_none;
        logic shift_last;
        logic out_free;
    } mpq_stat_t;

endpackage

FILE: rtl/core/mpq_ram.sv
`timescale 1ns / 1ps

module mpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/mpq_datapath.sv
`timescale 1ns / 1ps

module mpq_datapath #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_op,
    input  logic signed [31:0]  s_value,
    input  logic                m_ready,
    output logic                m_valid,
    output logic signed [31:0]  m_removed_value,
    output logic [1:0]          m_status,
    input  mpq_pkg::mpq_cmd_t   cmd,
    output mpq_pkg::mpq_stat_t  stat
);
    import mpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic                          req_op_reg;
    logic signed [31:0]            req_value_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 ptr_reg;
    logic [AW-1:0]                 data_idx_reg;
    logic [AW-1:0]                 wr_ptr_reg;
    logic                          scan_first_reg;
    logic signed [VALUE_WIDTH-1:0] min_val_reg;
    logic [AW-1:0]                 min_idx_reg;
    logic signed [31:0]            res_value_reg;
    logic [1:0]                    res_status_reg;
    logic                          m_valid_reg;
    logic signed [31:0]            m_value_reg;
    logic [1:0]                    m_status_reg;

    logic                          ram_wr_en;
    logic [AW-1:0]                 ram_wr_addr;
    logic [VALUE_WIDTH-1:0]        ram_wr_data;
    logic [AW-1:0]                 ram_rd_addr;
    logic [VALUE_WIDTH-1:0]        ram_rd_data;
    logic signed [VALUE_WIDTH-1:0] rd_val;
    logic                          take_min;

    mpq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_val   = $signed(ram_rd_data);
    assign take_min = scan_first_reg || (rd_val < min_val_reg);

    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = count_reg[AW-1:0];
        ram_wr_data = VALUE_WIDTH'(req_value_reg);
        ram_rd_addr = ptr_reg[AW-1:0];
        if (cmd.push) begin
            ram_wr_en = 1'b1;
        end
        if (cmd.shift_step) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = wr_ptr_reg;
            ram_wr_data = ram_rd_data;
        end
        if (cmd.scan_start) begin
            ram_rd_addr = '0;
        end
        if (cmd.shift_start) begin
            ram_rd_addr = min_idx_reg + AW'(1);
        end
    end

    always_comb begin
        stat.op_remove  = (req_op_reg == OP_REMOVE);
        stat.is_full    = (count_reg == CW'(CAPACITY));
        stat.is_empty   = (count_reg == '0);
        stat.scan_last  = (CW'(data_idx_reg) == count_reg - CW'(1));
        stat.shift_none = (CW'(min_idx_reg) == count_reg - CW'(1));
        stat.shift_last = (CW'(wr_ptr_reg) == count_reg - CW'(2));
        stat.out_free   = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.push) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.finish_remove) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_op_reg    <= s_op;
            req_value_reg <= s_value;
        end
        if (cmd.push) begin
            res_value_reg  <= '0;
            res_status_reg <= ST_OK;
        end
        if (cmd.flag_full) begin
            res_value_reg  <= '0;
            res_status_reg <= ST_FULL;
        end
        if (cmd.flag_empty) begin
            res_value_reg  <= '0;
            res_status_reg <= ST_EMPTY;
        end
        if (cmd.finish_remove) begin
            res_value_reg  <= 32'(min_val_reg);
            res_status_reg <= ST_OK;
        end
        if (cmd.scan_start) begin
            ptr_reg        <= CW'(1);
            data_idx_reg   <= '0;
            scan_first_reg <= 1'b1;
        end
        if (cmd.scan_step) begin
            scan_first_reg <= 1'b0;
            data_idx_reg   <= ptr_reg[AW-1:0];
            ptr_reg        <= ptr_reg + CW'(1);
            if (take_min) begin
                min_val_reg <= rd_val;
                min_idx_reg <= data_idx_reg;
            end
        end
        if (cmd.shift_start) begin
            wr_ptr_reg <= min_idx_reg;
            ptr_reg    <= CW'(min_idx_reg) + CW'(2);
        end
        if (cmd.shift_step) begin
            wr_ptr_reg <= wr_ptr_reg + AW'(1);
            ptr_reg    <= ptr_reg + CW'(1);
        end
        if (cmd.out_load) begin
            m_value_reg  <= res_value_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_removed_value = m_value_reg;
    assign m_status        = m_status_reg;

endmodule

FILE: rtl/core/mpq_ctrl.sv
`timescale 1ns / 1ps

module mpq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output mpq_pkg::mpq_cmd_t  cmd,
    input  mpq_pkg::mpq_stat_t stat
);
    import mpq_pkg::*;

    localparam logic [2:0] S_IDLE        = 3'd0;
    localparam logic [2:0] S_DECODE      = 3'd1;
    localparam logic [2:0] S_SCAN        = 3'd2;
    localparam logic [2:0] S_SHIFT_START = 3'd3;
    localparam logic [2:0] S_SHIFT       = 3'd4;
    localparam logic [2:0] S_FINISH      = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_FINISH;
                if (!stat.op_remove) begin
                    if (stat.is_full) begin
                        cmd.flag_full = 1'b1;
                    end else begin
                        cmd.push = 1'b1;
                    end
                end else if (stat.is_empty) begin
                    cmd.flag_empty = 1'b1;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last) begin
                    state_next = S_SHIFT_START;
                end
            end
            S_SHIFT_START: begin
                if (stat.shift_none) begin
                    cmd.finish_remove = 1'b1;
                    state_next        = S_FINISH;
                end else begin
                    cmd.shift_start = 1'b1;
                    state_next      = S_SHIFT;
                end
            end
            S_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (stat.shift_last) begin
                    cmd.finish_remove = 1'b1;
                    state_next        = S_FINISH;
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/min_priority_queue_linear_scan_top.sv
`timescale 1ns / 1ps
// Bounded minimum priority queue, unsorted store in insertion order.
// Input channel s_*: op 0 pushes s_value, op 1 removes the lowest value
// (earliest inserted wins on ties). Each request gives one result on m_*:
// m_removed_value (zero unless a successful remove) and m_status
// (0 ok, 1 empty on remove, 2 full on push).
// Push, or any rejected request: the request is registered and decoded, and
// its result is then loaded onto m_* as s_ready returns high.
// Remove: the single read port of the store scans one entry per cycle to
// find the lowest, then moves each later entry down by one place, one per
// cycle; the result is then loaded onto m_* as s_ready returns high.
// One request is processed at a time; s_ready is high only while idle.
// A new request may be accepted while the previous result is still held on
// m_*; if the receiver stalls, the next result waits until m_ready.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; store contents are not cleared.
module min_priority_queue_linear_scan_top #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic signed [31:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_removed_value,
    output logic [1:0]         m_status
);
    import mpq_pkg::*;

    mpq_cmd_t  cmd;
    mpq_stat_t stat;

    mpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    mpq_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_op            (s_op),
        .s_value         (s_value),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_removed_value (m_removed_value),
        .m_status        (m_status),
        .cmd             (cmd),
        .stat            (stat)
    );

endmodule
